FILE: hw/rtl/adc_spi_read_frame_checker_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ADC serial read frame checker
// Implication helpers shared by the checker RTL files.
// ----------------------------------------------------------------------------
`ifndef ADC_SPI_READ_FRAME_CHECKER_UNIT_DEFINES_SVH
`define ADC_SPI_READ_FRAME_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define ASRFC_ASSERT(LABEL, CLK, RST, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |-> (CONS)) \
    else $error(MSG);

// next-cycle implication
`define ASRFC_ASSERT_NEXT(LABEL, CLK, RST, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

FILE: hw/rtl/asrfc_pkg.sv
// ----------------------------------------------------------------------------
// asrfc_pkg
// Types and constants of the ADC serial read frame checker.
// ----------------------------------------------------------------------------
package asrfc_pkg;

  localparam int ByteW    = 8;
  localparam int ValueW   = 40;
  localparam int ModeW    = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [ByteW-1:0] CrcTopBit   = 8'h80;
  localparam logic [ByteW-1:0] CrcPolyRst  = 8'h07;

  // check modes; the unused code behaves as no check
  localparam logic [ModeW-1:0] ModeNone = 2'd0;
  localparam logic [ModeW-1:0] ModeCrc  = 2'd1;
  localparam logic [ModeW-1:0] ModeXor  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCheckMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCrcPoly   = 2'd1;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } step_t;

  typedef struct packed {
    logic [ValueW-1:0] read_value;
    logic [ByteW-1:0]  check_residue;
    logic              frame_ok;
  } result_t;

endpackage

FILE: hw/rtl/asrfc_if.sv
// ----------------------------------------------------------------------------
// asrfc channel interfaces
// Byte input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface asrfc_in_if;
  import asrfc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_byte;
  logic             first_byte;
  logic             last_byte;

  modport source (output valid, frame_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, first_byte, last_byte, output ready);
endinterface

interface asrfc_out_if;
  import asrfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] read_value;
  logic [ByteW-1:0]  check_residue;
  logic              frame_ok;

  modport source (output valid, read_value, check_residue, frame_ok, input ready);
  modport sink   (input valid, read_value, check_residue, frame_ok, output ready);
endinterface

interface asrfc_cfg_if;
  import asrfc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/adc_spi_read_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// adc_spi_read_frame_checker_unit
// Checks CRC-8 or XOR of serial ADC read frames and assembles the data bytes.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                    | handshake
//  frame   | in  | frame_byte[7:0], first_byte, last_byte     | valid/ready
//  result  | out | read_value[39:0], check_residue[7:0], ok   | valid/ready
//  cfg     | in  | index[1:0], data[7:0]                      | valid/ready
//
//  One byte per cycle sustained while no last byte waits on a stalled result.
//  Stages: input register, then frame state update into the result register.
//  rst is synchronous: mode 0, polynomial 0x07, frame state cleared.
//  A stalled result only holds back a stage holding a frame's last byte.
//  cfg is always ready; writes take effect on the next byte processed.
// ----------------------------------------------------------------------------
`include "adc_spi_read_frame_checker_unit_defines.svh"

module adc_spi_read_frame_checker_unit #(
  parameter int MAX_DATA_BYTES = 5
) (
  input  logic        clk,
  input  logic        rst,
  asrfc_in_if.sink    frame,
  asrfc_out_if.source result,
  asrfc_cfg_if.sink   cfg
);
  import asrfc_pkg::*;

  logic [ModeW-1:0] check_mode;
  logic [ByteW-1:0] crc_poly;

  // input stage
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_first;
  logic             s1_last;
  logic             s1_consume;

  // result stage
  logic    res_valid;
  result_t res_next;
  result_t res;
  step_t   step;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode <= ModeNone;
      crc_poly   <= CrcPolyRst;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegCheckMode: check_mode <= cfg.data[ModeW-1:0];
        RegCrcPoly:   crc_poly   <= cfg.data;
        default: ;
      endcase
    end
  end

  // a byte that makes no result never waits on the output side
  assign s1_consume  = s1_valid && (!s1_last || !res_valid || result.ready);
  assign frame.ready = !s1_valid || s1_consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      s1_byte  <= frame.frame_byte;
      s1_first <= frame.first_byte;
      s1_last  <= frame.last_byte;
    end
  end

  assign step.valid = s1_consume;
  assign step.first = s1_first;
  assign step.last  = s1_last;

  asrfc_frame #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_frame (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data       (s1_byte),
    .check_mode (check_mode),
    .crc_poly   (crc_poly),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_consume && s1_last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_consume && s1_last) begin
      res <= res_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.read_value    = res.read_value;
  assign result.check_residue = res.check_residue;
  assign result.frame_ok      = res.frame_ok;

  `ASRFC_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_consume, s1_valid, "input stage dropped a byte")
  `ASRFC_ASSERT(a_no_overwrite, clk, rst, s1_consume && s1_last, !res_valid || result.ready, "result overwritten while pending")
  `ASRFC_ASSERT(a_ok_matches, clk, rst, res_valid, result.frame_ok == (result.check_residue == '0), "pass flag disagrees with residue")

endmodule

FILE: hw/rtl/asrfc_crc8.sv
// ----------------------------------------------------------------------------
// asrfc_crc8
// Byte-wide MSB-first CRC-8 update with a programmable polynomial.
// ----------------------------------------------------------------------------
module asrfc_crc8 (
  input  logic [7:0] crc,
  input  logic [7:0] data,
  input  logic [7:0] poly,
  output logic [7:0] crc_next
);
  import asrfc_pkg::*;

  always_comb begin
    logic [ByteW-1:0] r;
    r = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if ((r & CrcTopBit) != '0) begin
        r = {r[ByteW-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[ByteW-2:0], 1'b0};
      end
    end
    crc_next = r;
  end

endmodule

FILE: hw/rtl/asrfc_frame.sv
// ----------------------------------------------------------------------------
// asrfc_frame
// Per-frame state: running CRC, running XOR, data assembly and byte count.
// ----------------------------------------------------------------------------
`include "adc_spi_read_frame_checker_unit_defines.svh"

module asrfc_frame #(
  parameter int MAX_DATA_BYTES = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  asrfc_pkg::step_t           step,
  input  logic [7:0]                 data,
  input  logic [asrfc_pkg::ModeW-1:0] check_mode,
  input  logic [7:0]                 crc_poly,
  output asrfc_pkg::result_t         res
);
  import asrfc_pkg::*;

  localparam int CntW = $clog2(MAX_DATA_BYTES + 1);

  logic [ByteW-1:0]  running_crc, running_crc_next;
  logic [ByteW-1:0]  running_xor, running_xor_next;
  logic [ValueW-1:0] value_acc, value_acc_next;
  logic [CntW-1:0]   data_count, data_count_next;

  logic [ByteW-1:0]  crc_base, xor_base;
  logic [ValueW-1:0] acc_base;
  logic [CntW-1:0]   cnt_base;
  logic              checked;
  logic              take;
  logic [ByteW-1:0]  residue;

  // a start mark drops whatever the previous frame left
  assign crc_base = step.first ? '0 : running_crc;
  assign xor_base = step.first ? '0 : running_xor;
  assign acc_base = step.first ? '0 : value_acc;
  assign cnt_base = step.first ? '0 : data_count;

  asrfc_crc8 u_crc (
    .crc      (crc_base),
    .data     (data),
    .poly     (crc_poly),
    .crc_next (running_crc_next)
  );

  assign running_xor_next = xor_base ^ data;
  assign checked = (check_mode == ModeCrc) || (check_mode == ModeXor);
  // in a checked mode the closing byte is the check byte, not data
  assign take = !step.first && (!step.last || !checked);

  always_comb begin
    value_acc_next  = acc_base;
    data_count_next = cnt_base;
    if (take && (cnt_base < CntW'(MAX_DATA_BYTES))) begin
      value_acc_next  = {acc_base[ValueW-ByteW-1:0], data};
      data_count_next = cnt_base + CntW'(1);
    end
  end

  always_comb begin
    unique case (check_mode)
      ModeCrc: residue = running_crc_next;
      ModeXor: residue = running_xor_next;
      default: residue = '0;
    endcase
  end

  assign res.read_value    = value_acc_next;
  assign res.check_residue = residue;
  assign res.frame_ok      = (residue == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      running_xor <= '0;
      value_acc   <= '0;
      data_count  <= '0;
    end else if (step.valid) begin
      if (step.last) begin
        running_crc <= '0;
        running_xor <= '0;
        value_acc   <= '0;
        data_count  <= '0;
      end else begin
        running_crc <= running_crc_next;
        running_xor <= running_xor_next;
        value_acc   <= value_acc_next;
        data_count  <= data_count_next;
      end
    end
  end

  `ASRFC_ASSERT(a_count_bound, clk, rst, 1'b1, data_count <= CntW'(MAX_DATA_BYTES), "data count past limit")
  `ASRFC_ASSERT_NEXT(a_clear_after_last, clk, rst, step.valid && step.last, (data_count == '0) && (running_crc == '0) && (running_xor == '0), "frame state not cleared after last byte")
  `ASRFC_ASSERT_NEXT(a_hold_when_idle, clk, rst, !step.valid, $stable(running_crc) && $stable(value_acc), "frame state moved without a byte")

endmodule

FILE: dv/asrfc_result_checker.sv
// ----------------------------------------------------------------------------
// asrfc_result_checker
// Watches the byte, result and cfg channels of the read frame checker. It
// tracks the CRC-8, XOR and big-endian data assembly of each frame on its
// own, queues the expected result on every last byte and compares each
// result transaction with the oldest entry, field by field.
// ----------------------------------------------------------------------------
module asrfc_result_checker #(
  parameter int MAX_DATA_BYTES = 5
) (
  input  logic  clk,
  input  logic  rst,
  asrfc_in_if   frame,
  asrfc_out_if  result,
  asrfc_cfg_if  cfg,
  output int    outstanding,
  output int    mismatches
);
  import asrfc_pkg::*;

  localparam int ReportLimit = 10;

  logic [ModeW-1:0]  mode_q;
  logic [ByteW-1:0]  poly_q;
  logic [ByteW-1:0]  frame_crc;
  logic [ByteW-1:0]  frame_xor;
  logic [ValueW-1:0] assembled;
  logic [2:0]        data_taken;
  int                fail_count;
  result_t           expected_reads[$];

  function automatic void clear_frame();
    frame_crc  = '0;
    frame_xor  = '0;
    assembled  = '0;
    data_taken = '0;
  endfunction

  always @(posedge clk) begin : predict
    result_t          got;
    result_t          want;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] residue;
    logic             checked;
    if (rst) begin
      mode_q = ModeNone;
      poly_q = CrcPolyRst;
      clear_frame();
      expected_reads.delete();
      fail_count = 0;
    end else begin
      // results leave before this edge's byte can add a new expectation
      if (result.valid && result.ready) begin
        got.read_value    = result.read_value;
        got.check_residue = result.check_residue;
        got.frame_ok      = result.frame_ok;
        if (expected_reads.size() == 0) begin
          if (fail_count < ReportLimit)
            $display("unexpected result transaction: value %h residue %h ok %b",
                     got.read_value, got.check_residue, got.frame_ok);
          fail_count++;
        end else begin
          want = expected_reads.pop_front();
          if (got.read_value !== want.read_value ||
              got.check_residue !== want.check_residue ||
              got.frame_ok !== want.frame_ok) begin
            if (fail_count < ReportLimit)
              $display("result mismatch: expected value %h residue %h ok %b, got value %h residue %h ok %b",
                       want.read_value, want.check_residue, want.frame_ok,
                       got.read_value, got.check_residue, got.frame_ok);
            fail_count++;
          end
        end
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          RegCheckMode: mode_q = cfg.data[ModeW-1:0];
          RegCrcPoly:   poly_q = cfg.data;
          default: ;
        endcase
      end

      if (frame.valid && frame.ready) begin
        b = frame.frame_byte;
        if (frame.first_byte) clear_frame();
        residue = frame_crc ^ b;
        for (int k = 0; k < ByteW; k++) begin
          if ((residue & CrcTopBit) != 0) residue = (residue << 1) ^ poly_q;
          else residue = residue << 1;
        end
        frame_crc = residue;
        frame_xor = frame_xor ^ b;
        checked   = (mode_q == ModeCrc) || (mode_q == ModeXor);
        // the check byte of a checked frame is not data; extra data bytes are dropped
        if (!frame.first_byte && (!frame.last_byte || !checked) &&
            data_taken < MAX_DATA_BYTES) begin
          assembled  = {assembled[ValueW-ByteW-1:0], b};
          data_taken = data_taken + 3'd1;
        end
        if (frame.last_byte) begin
          if (mode_q == ModeCrc) residue = frame_crc;
          else if (mode_q == ModeXor) residue = frame_xor;
          else residue = '0;
          want.read_value    = assembled;
          want.check_residue = residue;
          want.frame_ok      = (residue == '0);
          expected_reads.push_back(want);
          clear_frame();
        end
      end
    end
    outstanding <= expected_reads.size();
    mismatches  <= fail_count;
  end

endmodule

FILE: dv/tb_adc_spi_read_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// tb_adc_spi_read_frame_checker_unit
// Drives read frames into the frame checker: a directed set covering
// missing start marks, one-byte frames, data overflow and every check mode,
// then randomized phases of well-formed frames with good and corrupted
// check bytes mixed with loose bytes, each phase under a new mode and
// polynomial. Both sides idle at random; the result side holds off once.
// ----------------------------------------------------------------------------
module tb_adc_spi_read_frame_checker_unit;
  import asrfc_pkg::*;

  localparam int MaxDataBytes = 5;
  localparam int RandomItems  = 1100;
  localparam int PhaseItems   = 150;
  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 8;
  localparam int StallLimit   = 2000;
  localparam int IdlePct      = 30;

  // mode code 3 has no name in the package; the block treats it as no check
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;

  typedef logic [ByteW-1:0] byte_q_t[$];

  logic             clk = 1'b0;
  logic             rst;
  logic             steady;
  logic             hold_go;
  logic             sink_hold;
  logic [ModeW-1:0] cur_mode;
  logic [ByteW-1:0] cur_poly;
  int               bytes_sent;
  int               outstanding;
  int               mismatches;

  asrfc_in_if  frame_if();
  asrfc_out_if result_if();
  asrfc_cfg_if cfg_if();

  adc_spi_read_frame_checker_unit #(
    .MAX_DATA_BYTES(MaxDataBytes)
  ) i_dut (
    .clk,
    .rst,
    .frame(frame_if),
    .result(result_if),
    .cfg(cfg_if)
  );

  asrfc_result_checker #(
    .MAX_DATA_BYTES(MaxDataBytes)
  ) i_chk (
    .clk,
    .rst,
    .frame(frame_if),
    .result(result_if),
    .cfg(cfg_if),
    .outstanding,
    .mismatches
  );

  always #6 clk = ~clk;

  task automatic send_byte(input logic [ByteW-1:0] b, input logic first, input logic last);
    while (!steady && $urandom_range(99) < IdlePct) begin
      frame_if.valid <= 1'b0;
      @(posedge clk);
    end
    frame_if.valid      <= 1'b1;
    frame_if.frame_byte <= b;
    frame_if.first_byte <= first;
    frame_if.last_byte  <= last;
    do @(posedge clk); while (!frame_if.ready);
    bytes_sent++;
  endtask

  // command byte, data bytes, then a check byte when the current mode checks
  task automatic send_frame(input logic [ByteW-1:0] cmd, input byte_q_t data, input bit good);
    byte_q_t          body;
    logic [ByteW-1:0] crc;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] flip;
    body = data;
    body.push_front(cmd);
    crc  = '0;
    sum  = '0;
    flip = good ? 8'h00 : ByteW'($urandom_range(1, 255));
    foreach (body[i]) begin
      crc = crc ^ body[i];
      for (int k = 0; k < ByteW; k++)
        crc = ((crc & CrcTopBit) != 0) ? ((crc << 1) ^ cur_poly) : (crc << 1);
      sum = sum ^ body[i];
    end
    if (cur_mode == ModeCrc) body.push_back(crc ^ flip);
    else if (cur_mode == ModeXor) body.push_back(sum ^ flip);
    foreach (body[i]) send_byte(body[i], i == 0, i == body.size() - 1);
  endtask

  task automatic configure(input logic [ModeW-1:0] mode, input logic [ByteW-1:0] poly);
    logic [CfgDataW-1:0] word;
    word = CfgDataW'($urandom);
    word[ModeW-1:0] = mode;  // upper bits are don't-care for the mode register
    cfg_if.valid <= 1'b1;
    cfg_if.index <= RegCheckMode;
    cfg_if.data  <= word;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= RegCrcPoly;
    cfg_if.data  <= poly;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_mode = mode;
    cur_poly = poly;
  endtask

  // stop sending, wait for every expected result, then let the pipe empty
  task automatic settle();
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin : result_sink
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_if.ready <= !rst && !sink_hold && (steady || $urandom_range(99) >= IdlePct);
    end
  end

  initial begin : result_hold
    sink_hold = 1'b0;
    wait (hold_go === 1'b1);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk);
      if (rst || (frame_if.valid && frame_if.ready) ||
          (result_if.valid && result_if.ready) || (cfg_if.valid && cfg_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    byte_q_t          data;
    int               phase;
    int               quota;
    int               start;
    int               n;
    bit               open_frame;
    logic [ModeW-1:0] mode;
    logic [ByteW-1:0] poly;
    rst                 = 1'b1;
    frame_if.valid      = 1'b0;
    frame_if.frame_byte = '0;
    frame_if.first_byte = 1'b0;
    frame_if.last_byte  = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = RegCheckMode;
    cfg_if.data         = '0;
    steady              = 1'b0;
    hold_go             = 1'b0;
    cur_mode            = ModeNone;
    cur_poly            = CrcPolyRst;
    bytes_sent          = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no check, poly 0x07; bytes with no start mark first
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    data = {8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66};
    send_frame(8'h00, data, 1'b1);
    settle();

    configure(ModeCrc, CrcPolyRst);
    data = {8'h80, 8'h7F, 8'h01};
    send_frame(8'hC3, data, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    settle();

    configure(ModeXor, 8'hFF);
    data = {8'h01, 8'hFE};
    send_frame(8'h80, data, 1'b1);
    data.delete();
    send_frame(8'h12, data, 1'b0);
    settle();

    configure(ModeUnused, 8'h00);
    data = {8'hAA, 8'hFF};
    send_frame(8'h55, data, 1'b1);

    start      = bytes_sent;
    phase      = 0;
    open_frame = 1'b0;
    while (bytes_sent - start < RandomItems) begin
      settle();
      case (phase % 5)
        0:       mode = ModeCrc;
        1:       mode = ModeXor;
        2:       mode = ModeNone;
        3:       mode = ModeCrc;
        default: mode = ModeUnused;
      endcase
      case (phase % 4)
        1:       poly = 8'hFF;
        2:       poly = 8'h00;
        default: poly = ByteW'($urandom);
      endcase
      configure(mode, poly);
      steady <= (phase == 2);
      quota = bytes_sent + PhaseItems;
      // close the frame left open before the settings changed
      if (open_frame) begin
        repeat ($urandom_range(0, 3)) send_byte(ByteW'($urandom), 1'b0, 1'b0);
        send_byte(ByteW'($urandom), 1'b0, 1'b1);
      end
      while (bytes_sent < quota) begin
        if (phase == 1 && !hold_go && quota - bytes_sent < 110) hold_go <= 1'b1;
        if ($urandom_range(99) < 80) begin
          data.delete();
          if ($urandom_range(9) < 8) n = $urandom_range(1, MaxDataBytes);
          else if ($urandom_range(1) == 0) n = 0;
          else n = $urandom_range(MaxDataBytes + 1, 7);
          repeat (n) data.push_back(ByteW'($urandom));
          send_frame(ByteW'($urandom), data, $urandom_range(9) < 7);
        end else begin
          repeat ($urandom_range(1, 4))
            send_byte(ByteW'($urandom), $urandom_range(3) == 0, $urandom_range(2) == 0);
        end
      end
      open_frame = $urandom_range(1);
      if (open_frame) begin
        send_byte(ByteW'($urandom), 1'b1, 1'b0);
        repeat ($urandom_range(0, 3)) send_byte(ByteW'($urandom), 1'b0, 1'b0);
      end
      phase++;
    end
    settle();

    if (mismatches == 0 && outstanding == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
